[rtl/lchase_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lchase_pkg
// shared types, register indexes and reset values for the lamp chase
// alarm sequencer
// ---------------------------------------------------------------------------
package lchase_pkg;

	// default number of lamps in the chase (1 to 4, the width of the lamp pattern)
	localparam int LAMP_COUNT_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TS_W       = 32;
	localparam int LAMP_W     = 3;
	localparam int BLINK_W    = 3;
	localparam int PATTERN_W  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERIOD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BEEP_INTERVAL  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RUNNING_PERIOD_RST = 16'd500;
	localparam logic [CFG_DATA_W-1:0] ALARM_PERIOD_RST   = 16'd100;
	localparam logic [CFG_DATA_W-1:0] BEEP_INTERVAL_RST  = 16'd500;

	typedef enum logic [1:0] {
		MD_OFF   = 2'd0,
		MD_CHASE = 2'd1,
		MD_ALERT = 2'd2,
		MD_HOLD  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t           mode;
		logic [TS_W-1:0] now_ms;
	} poll_t;

	typedef struct packed {
		logic [PATTERN_W-1:0] lamp_pattern;
		logic                 buzzer_drive;
	} result_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] running_period;
		logic [CFG_DATA_W-1:0] alarm_period;
		logic [CFG_DATA_W-1:0] beep_interval;
	} cfg_t;

endpackage : lchase_pkg
`default_nettype wire

[rtl/lchase_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lchase_seq
// sequencer state and its single-pass update for one poll, result derived
// from the updated state
// ---------------------------------------------------------------------------
module lchase_seq #(
	parameter int LAMP_COUNT = lchase_pkg::LAMP_COUNT_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step_en,
	input  wire lchase_pkg::poll_t poll,
	input  wire lchase_pkg::cfg_t  cfg,
	output lchase_pkg::result_t  result
);
	import lchase_pkg::*;

	logic [LAMP_W-1:0]  active_lamp_q, active_lamp_d;
	logic               lamp_is_lit_q, lamp_is_lit_d;
	logic [BLINK_W-1:0] blinks_done_q, blinks_done_d;
	logic [TS_W-1:0]    last_lamp_step_q, last_lamp_step_d;
	logic               buzzer_is_on_q, buzzer_is_on_d;
	logic [TS_W-1:0]    last_buzz_step_q, last_buzz_step_d;

	logic [TS_W-1:0]       lamp_elapsed;
	logic [TS_W-1:0]       buzz_elapsed;
	logic [CFG_DATA_W-1:0] lamp_period;
	logic                  lamp_due;
	logic                  buzz_due;
	logic [BLINK_W-1:0]    blinks_inc;
	logic [LAMP_W:0]       lamp_inc;
	logic [(1<<LAMP_W)-1:0] lamp_onehot;

	assign lamp_elapsed = poll.now_ms - last_lamp_step_q;
	assign buzz_elapsed = poll.now_ms - last_buzz_step_q;
	assign lamp_period  = (poll.mode == MD_ALERT) ? cfg.alarm_period : cfg.running_period;
	assign lamp_due     = lamp_elapsed >= {{(TS_W-CFG_DATA_W){1'b0}}, lamp_period};
	assign buzz_due     = buzz_elapsed >= {{(TS_W-CFG_DATA_W){1'b0}}, cfg.beep_interval};
	assign blinks_inc   = blinks_done_q + BLINK_W'(1);
	assign lamp_inc     = {1'b0, active_lamp_q} + (LAMP_W+1)'(1);

	always_comb begin
		active_lamp_d    = active_lamp_q;
		lamp_is_lit_d    = lamp_is_lit_q;
		blinks_done_d    = blinks_done_q;
		last_lamp_step_d = last_lamp_step_q;
		buzzer_is_on_d   = buzzer_is_on_q;
		last_buzz_step_d = last_buzz_step_q;
		unique case (poll.mode)
			MD_OFF: begin
				active_lamp_d  = LAMP_W'(1);
				lamp_is_lit_d  = 1'b0;
				blinks_done_d  = '0;
				buzzer_is_on_d = 1'b0;
			end
			MD_CHASE, MD_ALERT: begin
				if (poll.mode == MD_CHASE) begin
					buzzer_is_on_d = 1'b0;
				end else if (buzz_due) begin
					last_buzz_step_d = poll.now_ms;
					buzzer_is_on_d   = ~buzzer_is_on_q;
				end
				if (lamp_due) begin
					last_lamp_step_d = poll.now_ms;
					if (!lamp_is_lit_q) begin
						lamp_is_lit_d = 1'b1;
					end else begin
						lamp_is_lit_d = 1'b0;
						// lamp n finishes after n blinks
						if ({1'b0, blinks_inc} >= {1'b0, active_lamp_q}) begin
							blinks_done_d = '0;
							if (lamp_inc > (LAMP_W+1)'(LAMP_COUNT)) begin
								active_lamp_d = LAMP_W'(1);
							end else begin
								active_lamp_d = lamp_inc[LAMP_W-1:0];
							end
						end else begin
							blinks_done_d = blinks_inc;
						end
					end
				end
			end
			MD_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	// bit n of the one-hot is lamp n, bit 0 never used
	assign lamp_onehot         = (1 << LAMP_W)'(1) << active_lamp_d;
	assign result.lamp_pattern = lamp_is_lit_d ? lamp_onehot[PATTERN_W:1] : '0;
	assign result.buzzer_drive = buzzer_is_on_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_lamp_q    <= LAMP_W'(1);
			lamp_is_lit_q    <= 1'b0;
			blinks_done_q    <= '0;
			last_lamp_step_q <= '0;
			buzzer_is_on_q   <= 1'b0;
			last_buzz_step_q <= '0;
		end else if (step_en) begin
			active_lamp_q    <= active_lamp_d;
			lamp_is_lit_q    <= lamp_is_lit_d;
			blinks_done_q    <= blinks_done_d;
			last_lamp_step_q <= last_lamp_step_d;
			buzzer_is_on_q   <= buzzer_is_on_d;
			last_buzz_step_q <= last_buzz_step_d;
		end
	end

endmodule : lchase_seq
`default_nettype wire

[rtl/led_chase_alarm_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// path: a poll is registered at acceptance, its result is registered in the result register
// throughput: one poll per cycle while the result side does not stall, the state
//   update is a single pass between the poll register and the result register
// reset: all state and config registers are cleared asynchronously to their
//   documented values, no clearing pass, polls accepted right after reset
// ---------------------------------------------------------------------------
// led_chase_alarm_sequencer_core
// polled lamp chase with alarm buzzer; each poll transaction yields one
// result transaction with the lamp pattern and buzzer drive
// ---------------------------------------------------------------------------
module led_chase_alarm_sequencer_core #(
	parameter int LAMP_COUNT = lchase_pkg::LAMP_COUNT_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// poll channel
	input  wire                                 poll_valid,
	output logic                                poll_stall,
	input  wire lchase_pkg::poll_t              poll,
	// result channel
	output logic                                result_valid,
	input  wire                                 result_stall,
	output lchase_pkg::result_t                 result,
	// config write port
	input  wire                                 cfg_we,
	input  wire [lchase_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [lchase_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import lchase_pkg::*;

	cfg_t    cfg_q;
	logic    poll_valid_s1;
	poll_t   poll_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t result_d;
	logic    advance;
	logic    accept;

	// the poll stage moves on whenever the result register is free or drained
	assign advance    = !result_valid_q || !result_stall;
	// the poll register only holds when it is full and cannot move on
	assign poll_stall = poll_valid_s1 && !advance;
	assign accept     = poll_valid && !poll_stall;

	// config registers, to be written only while no transaction is in flight (the block does not enforce it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.running_period <= RUNNING_PERIOD_RST;
			cfg_q.alarm_period   <= ALARM_PERIOD_RST;
			cfg_q.beep_interval  <= BEEP_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RUNNING_PERIOD: cfg_q.running_period <= cfg_wdata;
				CFG_ALARM_PERIOD:   cfg_q.alarm_period   <= cfg_wdata;
				CFG_BEEP_INTERVAL:  cfg_q.beep_interval  <= cfg_wdata;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid_s1 <= 1'b0;
		end else if (!poll_stall) begin
			poll_valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			poll_s1 <= poll;
		end
	end

	// sequencer state steps once per poll, as the poll enters the result register
	lchase_seq #(
		.LAMP_COUNT(LAMP_COUNT)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (poll_valid_s1 && advance),
		.poll    (poll_s1),
		.cfg     (cfg_q),
		.result  (result_d)
	);

	// result register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= poll_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid_s1 && advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule : led_chase_alarm_sequencer_core
`default_nettype wire

[sim/tb_led_chase_alarm_sequencer_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_led_chase_alarm_sequencer_core
// self-checking bench for the lamp chase alarm sequencer: polls go in with
// random handshake gaps, a scoreboard predicts each result and compares it
// field by field, and the run steps through several register settings
// ---------------------------------------------------------------------------
module tb_led_chase_alarm_sequencer_core;

	import lchase_pkg::*;

	localparam int LAMPS = LAMP_COUNT_DEF;

	// tracks the chase state and the results still owed by the block
	class chase_scoreboard;
		logic [CFG_DATA_W-1:0] run_period;
		logic [CFG_DATA_W-1:0] alarm_period;
		logic [CFG_DATA_W-1:0] beep_gap;
		logic [LAMP_W-1:0]     lamp;
		logic                  lit;
		logic [BLINK_W-1:0]    blinks;
		logic [TS_W-1:0]       lamp_stamp;
		logic                  buzz;
		logic [TS_W-1:0]       buzz_stamp;
		result_t               owed_results[$];
		int                    errors;
		int                    polls;
		int                    checked;

		function new();
			run_period   = RUNNING_PERIOD_RST;
			alarm_period = ALARM_PERIOD_RST;
			beep_gap     = BEEP_INTERVAL_RST;
			lamp         = 3'd1;
			lit          = 1'b0;
			blinks       = '0;
			lamp_stamp   = '0;
			buzz         = 1'b0;
			buzz_stamp   = '0;
			errors       = 0;
			polls        = 0;
			checked      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_RUNNING_PERIOD: run_period = val;
				CFG_ALARM_PERIOD:   alarm_period = val;
				CFG_BEEP_INTERVAL:  beep_gap = val;
				default: ;
			endcase
		endfunction

		// one lamp toggle when a full period has gone by
		function void step_lamp(logic [TS_W-1:0] now_ms, logic [CFG_DATA_W-1:0] period);
			logic [TS_W-1:0] elapsed;
			elapsed = now_ms - lamp_stamp;
			if (elapsed < {16'd0, period})
				return;
			lamp_stamp = now_ms;
			if (!lit) begin
				lit = 1'b1;
			end else begin
				lit    = 1'b0;
				blinks = blinks + 3'd1;
				if (blinks >= lamp) begin
					blinks = '0;
					if (lamp >= LAMPS)
						lamp = 3'd1;
					else
						lamp = lamp + 3'd1;
				end
			end
		endfunction

		function void note_poll(poll_t p);
			logic [7:0] wide;
			result_t    exp_res;
			case (p.mode)
				MD_OFF: begin
					lamp   = 3'd1;
					lit    = 1'b0;
					blinks = '0;
					buzz   = 1'b0;
				end
				MD_CHASE: begin
					buzz = 1'b0;
					step_lamp(p.now_ms, run_period);
				end
				MD_ALERT: begin
					if (p.now_ms - buzz_stamp >= {16'd0, beep_gap}) begin
						buzz_stamp = p.now_ms;
						buzz       = !buzz;
					end
					step_lamp(p.now_ms, alarm_period);
				end
				default: ;
			endcase
			wide = lit ? (8'd1 << (lamp - 3'd1)) : 8'd0;
			exp_res.lamp_pattern = wide[PATTERN_W-1:0];
			exp_res.buzzer_drive = buzz;
			owed_results.push_back(exp_res);
			polls++;
		endfunction

		function void check_result(result_t r);
			result_t exp_res;
			if (owed_results.size() == 0) begin
				$error("result transaction with nothing expected: lamp_pattern %0h buzzer_drive %0b",
					r.lamp_pattern, r.buzzer_drive);
				errors++;
				return;
			end
			exp_res = owed_results.pop_front();
			checked++;
			if (r.lamp_pattern !== exp_res.lamp_pattern) begin
				$error("lamp_pattern mismatch: expected %0h actual %0h",
					exp_res.lamp_pattern, r.lamp_pattern);
				errors++;
			end
			if (r.buzzer_drive !== exp_res.buzzer_drive) begin
				$error("buzzer_drive mismatch: expected %0b actual %0b",
					exp_res.buzzer_drive, r.buzzer_drive);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  poll_valid;
	logic                  poll_stall;
	poll_t                 poll;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	chase_scoreboard sb = new();

	// quiet turns off all idling for the closing stretch of the run
	bit quiet = 1'b0;
	// when cleared, the poll side runs back to back for a while
	bit poll_gaps = 1'b1;
	int settings = 1;

	led_chase_alarm_sequencer_core #(
		.LAMP_COUNT(LAMPS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_stall   (poll_stall),
		.poll         (poll),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog: far above the slowest legal run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stall bursts, with calm stretches in between
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 40) == 0) begin
				// calm stretch, never stalls
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// every accepted result transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// one poll transaction, with an optional idle burst ahead of it
	task automatic send_poll(mode_t m, logic [TS_W-1:0] ms);
		poll_t p;
		p.mode   = m;
		p.now_ms = ms;
		if ($urandom_range(0, 29) == 0)
			poll_gaps = !poll_gaps;
		@(negedge clk);
		if (!quiet && poll_gaps && $urandom_range(0, 3) == 0) begin
			poll_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		poll_valid <= 1'b1;
		poll       <= p;
		// accepted at the first rising edge without stall
		do
			@(posedge clk);
		while (poll_stall);
		sb.note_poll(p);
	endtask

	// drop valid and wait until every owed result has come back
	task automatic settle();
		@(negedge clk);
		poll_valid <= 1'b0;
		wait (sb.owed_results.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// register write, only ever issued while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_all(logic [CFG_DATA_W-1:0] run_p, logic [CFG_DATA_W-1:0] alarm_p,
			logic [CFG_DATA_W-1:0] beep_p);
		settle();
		write_reg(CFG_RUNNING_PERIOD, run_p);
		write_reg(CFG_ALARM_PERIOD, alarm_p);
		write_reg(CFG_BEEP_INTERVAL, beep_p);
		settings++;
	endtask

	// random chase: the clock mostly moves by about one period so the
	// sequence walks through all lamps and wraps, with rare jumps and resets
	task automatic run_chase(int n);
		logic [TS_W-1:0] cursor;
		int unsigned     period;
		int unsigned     pick;
		mode_t           m;
		cursor = $urandom_range(0, 1) ? 32'hFFFF_0000 + $urandom_range(0, 65535) : $urandom;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				m = MD_OFF;
			else if (pick < 6)
				m = MD_HOLD;
			else if (pick < 50)
				m = MD_CHASE;
			else
				m = MD_ALERT;
			if (m == MD_ALERT)
				period = 32'($urandom_range(0, 1) ? sb.alarm_period : sb.beep_gap);
			else
				period = 32'(sb.run_period);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				cursor = cursor;
			else if (pick == 1)
				cursor = $urandom;
			else if (pick < 6)
				cursor = cursor + $urandom_range(0, period);
			else
				cursor = cursor + period + $urandom_range(0, period / 4);
			send_poll(m, cursor);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		poll_valid = 1'b0;
		poll       = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset values, each mode, exact period edges and wrap
		send_poll(MD_HOLD, 32'd0);              // unknown right after reset
		send_poll(MD_CHASE, 32'd0);             // no time passed
		send_poll(MD_CHASE, 32'd499);           // one short of the period
		send_poll(MD_CHASE, 32'd500);           // exactly one period, lamp 1 lit
		send_poll(MD_CHASE, 32'd1000);          // dark, on to lamp 2
		send_poll(MD_HOLD, 32'hFFFF_FFFF);      // nothing moves
		send_poll(MD_ALERT, 32'd1100);          // buzzer on and lamp 2 lit
		send_poll(MD_ALERT, 32'd1199);
		send_poll(MD_ALERT, 32'd1200);
		send_poll(MD_CHASE, 32'd1200);          // running forces the buzzer off
		send_poll(MD_OFF, 32'hFFFF_FFFF);       // everything off, stamps kept
		send_poll(MD_ALERT, 32'hFFFF_FF00);
		send_poll(MD_ALERT, 32'h0000_0063);     // elapsed across the timestamp wrap
		send_poll(MD_ALERT, 32'h0000_01F4);
		send_poll(MD_CHASE, 32'h8000_0000);
		send_poll(MD_OFF, 32'd0);

		// shortest periods
		write_all(16'd1, 16'd1, 16'd1);
		run_chase(150);
		// longest periods
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_chase(150);
		// zero period: every running or alarm poll toggles
		write_all(16'd0, 16'd0, 16'd0);
		run_chase(100);
		// random settings, the second ends without any idling
		write_all(CFG_DATA_W'($urandom_range(1, 65535)), CFG_DATA_W'($urandom_range(1, 2000)),
			CFG_DATA_W'($urandom_range(1, 65535)));
		run_chase(170);
		write_all(CFG_DATA_W'($urandom_range(1, 2000)), CFG_DATA_W'($urandom_range(1, 65535)),
			CFG_DATA_W'($urandom_range(1, 2000)));
		run_chase(90);
		quiet = 1'b1;
		run_chase(80);

		settle();
		repeat (10) @(posedge clk);
		$display("polls: %0d accepted, %0d results checked over %0d register settings",
			sb.polls, sb.checked, settings);
		$display("modes standby/running/alarm/unknown, period edges, zero periods, ms wrap");
		if (sb.errors == 0 && sb.owed_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
